/* rtl/core/fdc_pkg.sv */
package fdc_pkg;

	localparam int DEPTH_W   = 16;
	localparam int ROOT_W    = 5;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PAL_COUNT = 21;
	localparam int STEPS     = 8;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_COLOR = 2'd1,
		OP_LOAD  = 2'd2
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_FIXED  = 3'd0,
		CFG_MIN_VALUE  = 3'd1,
		CFG_MAX_FIXED  = 3'd2,
		CFG_MAX_VALUE  = 3'd3,
		CFG_REMAP_LEN  = 3'd4
	} cfg_idx_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_PICK,
		S_DIV,
		S_FIN
	} state_e;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [DEPTH_W-1:0] depth;
		logic [ROOT_W-1:0]  pix_root;
		logic               pixel_error;
		logic               first_pixel;
		logic [ROOT_W-1:0]  remap_slot;
		logic [ROOT_W-1:0]  remap_target;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       was_error;
		logic       bad_root;
	} out_beat_t;

	function automatic rgb_t palette_rgb(input logic [ROOT_W-1:0] idx);
		rgb_t c;
		unique case (idx)
			5'd0:  c = '{8'hFF, 8'h00, 8'h00};
			5'd1:  c = '{8'hFF, 8'h80, 8'h00};
			5'd2:  c = '{8'hFF, 8'hFF, 8'h00};
			5'd3:  c = '{8'h00, 8'hFF, 8'h00};
			5'd4:  c = '{8'h00, 8'hFF, 8'hFF};
			5'd5:  c = '{8'h00, 8'h00, 8'hFF};
			5'd6:  c = '{8'hFF, 8'h00, 8'hFF};
			5'd7:  c = '{8'hFF, 8'h80, 8'h80};
			5'd8:  c = '{8'hFF, 8'hC0, 8'h80};
			5'd9:  c = '{8'hFF, 8'hFF, 8'h80};
			5'd10: c = '{8'h80, 8'hFF, 8'h80};
			5'd11: c = '{8'h80, 8'hFF, 8'hFF};
			5'd12: c = '{8'h80, 8'h80, 8'hFF};
			5'd13: c = '{8'hFF, 8'h80, 8'hFF};
			5'd14: c = '{8'h80, 8'h00, 8'h00};
			5'd15: c = '{8'h80, 8'h40, 8'h00};
			5'd16: c = '{8'h80, 8'h80, 8'h00};
			5'd17: c = '{8'h00, 8'h80, 8'h00};
			5'd18: c = '{8'h00, 8'h80, 8'h80};
			5'd19: c = '{8'h00, 8'h00, 8'h80};
			5'd20: c = '{8'h80, 8'h00, 8'h80};
			default: c = '{8'h00, 8'h00, 8'h00};
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/fractal_depth_colorizer.sv */
// Colors fractal pixels by iteration depth. Scan and load beats leave the block in its idle state,
// so it is ready again on the next cycle. A color beat passes the calc and pick states (bound,
// clamp and remap lookup), then the shared three-lane quotient unit (one quotient bit per cycle
// for all three channels), which collects its quotient into the result register; the finish state
// then moves the result into the output register once that is free. Error, bad-root and zero-range
// pixels skip the quotient unit.
// The block takes no new beat while a color beat is in work, but does take one while a finished
// result waits in the output register. The remap table is a small memory with registered read;
// reading an entry that was never loaded gives an undefined color.
module fractal_depth_colorizer #(
	parameter int DEPTH_BITS    = 16,
	parameter int REMAP_ENTRIES = 32,
	parameter int PALETTE_SIZE  = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  fdc_pkg::in_beat_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fdc_pkg::out_beat_t                  out_data,
	input  logic                                cfg_we,
	input  logic [fdc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DW    = DEPTH_BITS;
	localparam int IDX_W = (REMAP_ENTRIES > 1) ? $clog2(REMAP_ENTRIES) : 1;

	fdc_pkg::state_e state_q, state_d;

	logic                        min_fixed_q;
	logic                        max_fixed_q;
	logic [fdc_pkg::DEPTH_W-1:0] min_value_q;
	logic [fdc_pkg::DEPTH_W-1:0] max_value_q;
	logic [fdc_pkg::LEN_W-1:0]   remap_len_q;
	logic [DW-1:0]               run_min_q;
	logic [DW-1:0]               run_max_q;

	logic [fdc_pkg::ROOT_W-1:0]  remap_mem [REMAP_ENTRIES];
	logic [fdc_pkg::ROOT_W-1:0]  map_q;

	logic [DW-1:0]               depth_q;
	logic [fdc_pkg::ROOT_W-1:0]  root_q;
	logic                        err_q;
	logic [DW-1:0]               d_q;
	logic [DW-1:0]               range_q;
	logic                        rz_q;
	fdc_pkg::out_beat_t          res_q;
	fdc_pkg::out_beat_t          out_q;
	logic                        out_valid_q;

	logic                        accept;
	logic [DW-1:0]               in_depth;
	logic [DW-1:0]               lo, hi;
	logic [DW-1:0]               seed_min, seed_max, new_min, new_max;
	logic [DW-1:0]               clamp_hi, clamp;
	logic [fdc_pkg::ROOT_W-1:0]  root_eff;
	logic                        bad;
	logic                        full;
	logic                        go_div;
	logic                        out_free;
	fdc_pkg::rgb_t               pal;
	fdc_pkg::rgb_t               quot;
	fdc_pkg::out_beat_t          pick_res;
	logic                        div_start;
	logic                        div_done;

	assign in_ready = (state_q == fdc_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_depth = DW'(in_data.depth);
	assign lo       = min_fixed_q ? DW'(min_value_q) : run_min_q;
	assign hi       = max_fixed_q ? DW'(max_value_q) : run_max_q;
	assign out_free = !out_valid_q || out_ready;

	// scan bound update
	always_comb begin
		seed_min = run_min_q;
		seed_max = run_max_q;
		if (in_data.first_pixel) begin
			if (!min_fixed_q) begin
				seed_min = max_fixed_q ? DW'(max_value_q) : in_depth;
			end
			if (!max_fixed_q) begin
				seed_max = min_fixed_q ? DW'(min_value_q) : seed_min;
			end
		end
		new_min = seed_min;
		new_max = seed_max;
		if (!in_data.pixel_error) begin
			if (!min_fixed_q && in_depth < seed_min) begin
				new_min = in_depth;
			end
			if (!max_fixed_q && in_depth > seed_max) begin
				new_max = in_depth;
			end
		end
	end

	// clamp, remap and result pick
	always_comb begin
		clamp_hi = (depth_q > hi) ? hi : depth_q;
		clamp    = (clamp_hi < lo) ? lo : clamp_hi;
		root_eff = root_q;
		if ({1'b0, root_q} < remap_len_q && {1'b0, root_q} < 6'(REMAP_ENTRIES)) begin
			root_eff = map_q;
		end
		bad    = ({1'b0, root_eff} >= 6'(PALETTE_SIZE)) ||
		         ({1'b0, root_eff} >= 6'(fdc_pkg::PAL_COUNT));
		pal    = fdc_pkg::palette_rgb(root_eff);
		full   = (d_q >= hi);
		go_div = !err_q && !bad && !rz_q;
		pick_res = '0;
		if (err_q) begin
			pick_res.red       = 8'hFF;
			pick_res.green     = 8'hFF;
			pick_res.blue      = 8'hFF;
			pick_res.was_error = 1'b1;
		end else if (bad) begin
			pick_res.bad_root = 1'b1;
		end else if (full) begin
			pick_res.red   = pal.red;
			pick_res.green = pal.green;
			pick_res.blue  = pal.blue;
		end
	end

	assign div_start = (state_q == fdc_pkg::S_PICK) && go_div;

	fdc_scaler #(
		.W (DW)
	) u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (d_q - lo),
		.den    (range_q),
		.color  (pal),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fdc_pkg::S_IDLE: begin
				if (accept && in_data.opcode == fdc_pkg::OP_COLOR) begin
					state_d = fdc_pkg::S_CALC;
				end
			end
			fdc_pkg::S_CALC: state_d = fdc_pkg::S_PICK;
			fdc_pkg::S_PICK: state_d = go_div ? fdc_pkg::S_DIV : fdc_pkg::S_FIN;
			fdc_pkg::S_DIV: begin
				if (div_done) begin
					state_d = fdc_pkg::S_FIN;
				end
			end
			fdc_pkg::S_FIN: begin
				if (out_free) begin
					state_d = fdc_pkg::S_IDLE;
				end
			end
			default: state_d = fdc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdc_pkg::S_IDLE;
			min_fixed_q <= 1'b0;
			max_fixed_q <= 1'b0;
			min_value_q <= '0;
			max_value_q <= '0;
			remap_len_q <= '0;
			run_min_q   <= '0;
			run_max_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					fdc_pkg::CFG_MIN_FIXED: min_fixed_q <= cfg_data[0];
					fdc_pkg::CFG_MIN_VALUE: min_value_q <= cfg_data;
					fdc_pkg::CFG_MAX_FIXED: max_fixed_q <= cfg_data[0];
					fdc_pkg::CFG_MAX_VALUE: max_value_q <= cfg_data;
					fdc_pkg::CFG_REMAP_LEN: remap_len_q <= cfg_data[fdc_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			if (accept && in_data.opcode == fdc_pkg::OP_SCAN) begin
				run_min_q <= new_min;
				run_max_q <= new_max;
			end
			if (state_q == fdc_pkg::S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// remap table
	always_ff @(posedge clk) begin
		if (accept && in_data.opcode == fdc_pkg::OP_LOAD &&
		    {1'b0, in_data.remap_slot} < 6'(REMAP_ENTRIES)) begin
			remap_mem[in_data.remap_slot[IDX_W-1:0]] <= in_data.remap_target;
		end
		if (state_q == fdc_pkg::S_CALC) begin
			map_q <= remap_mem[root_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			depth_q <= in_depth;
			root_q  <= in_data.pix_root;
			err_q   <= in_data.pixel_error;
		end
		if (state_q == fdc_pkg::S_CALC) begin
			d_q     <= clamp;
			range_q <= (hi > lo) ? hi - lo : '0;
			rz_q    <= !(hi > lo);
		end
		if (state_q == fdc_pkg::S_PICK) begin
			res_q <= pick_res;
		end
		if (state_q == fdc_pkg::S_DIV && div_done) begin
			res_q <= {quot, 2'b00};
		end
		if (state_q == fdc_pkg::S_FIN && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_color_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.opcode == fdc_pkg::OP_COLOR) |=> !in_ready)
		else $error("color beat did not hold off input");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == fdc_pkg::S_DIV))
		else $error("quotient unit finished outside its state");

	a_error_white: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.was_error) |->
		(!out_data.bad_root && out_data.red == 8'hFF && out_data.green == 8'hFF &&
		 out_data.blue == 8'hFF))
		else $error("error pixel result is not white");

	a_bad_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.bad_root) |->
		(out_data.red == 8'h00 && out_data.green == 8'h00 && out_data.blue == 8'h00))
		else $error("bad root result is not black");

endmodule

/* rtl/core/fdc_scaler.sv */
module fdc_scaler #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        num,
	input  logic [W-1:0]        den,
	input  fdc_pkg::rgb_t       color,
	output logic                done,
	output fdc_pkg::rgb_t       quot
);

	localparam int SW = W + 2;

	logic                busy_q;
	logic                done_q;
	logic [2:0]          cnt_q;
	logic [W-1:0]        num_q;
	logic [W-1:0]        den_q;
	logic [W-1:0]        rem_q [3];
	logic [7:0]          q_q   [3];
	logic [7:0]          c_q   [3];
	logic [W-1:0]        rem_d [3];
	logic [7:0]          q_d   [3];
	logic [SW-1:0]       s     [3];
	logic [SW-1:0]       den1;
	logic [SW-1:0]       den2;

	// per lane: s = 2*rem + bit*num, then take off 0, 1 or 2 times den
	always_comb begin
		den1 = SW'(den_q);
		den2 = {1'b0, den_q, 1'b0};
		for (int i = 0; i < 3; i++) begin
			s[i] = {1'b0, rem_q[i], 1'b0} + (c_q[i][7] ? SW'(num_q) : '0);
			if (s[i] >= den2) begin
				rem_d[i] = W'(s[i] - den2);
				q_d[i]   = 8'({q_q[i], 1'b0} + 9'd2);
			end else if (s[i] >= den1) begin
				rem_d[i] = W'(s[i] - den1);
				q_d[i]   = 8'({q_q[i], 1'b0} + 9'd1);
			end else begin
				rem_d[i] = W'(s[i]);
				q_d[i]   = {q_q[i][6:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= 3'(fdc_pkg::STEPS - 1);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 3'd1;
				busy_q <= (cnt_q != '0);
				done_q <= (cnt_q == '0);
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			c_q[0] <= color.red;
			c_q[1] <= color.green;
			c_q[2] <= color.blue;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				q_q[i]   <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_d[i];
				q_q[i]   <= q_d[i];
				c_q[i]   <= {c_q[i][6:0], 1'b0};
			end
		end
	end

	assign done       = done_q;
	assign quot.red   = q_q[0];
	assign quot.green = q_q[1];
	assign quot.blue  = q_q[2];

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fdc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_FIXED;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fractal_depth_colorizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic cfg_min_fixed = 1'b0;
	logic [15:0] cfg_min_value = '0;
	logic cfg_max_fixed = 1'b0;
	logic [15:0] cfg_max_value = '0;
	logic [5:0] cfg_remap_len = '0;
	logic [15:0] running_min = '0;
	logic [15:0] running_max = '0;
	logic [4:0] remap_table [32];
	logic [23:0] hue_table [21] = '{
		24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF,
		24'hFF00FF, 24'hFF8080, 24'hFFC080, 24'hFFFF80, 24'h80FF80, 24'h80FFFF,
		24'h8080FF, 24'hFF80FF, 24'h800000, 24'h804000, 24'h808000, 24'h008000,
		24'h008080, 24'h000080, 24'h800080
	};

	out_beat_t pending_colors [$];
	int unsigned fail_count = 0;
	int unsigned beats_sent = 0;
	int unsigned burst_left = 0;
	bit gaps_on = 1'b1;
	int unsigned hold_off_len = 0;
	int unsigned quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic in_beat_t beat(logic [1:0] op, logic [15:0] d, logic [4:0] r, logic e,
			logic f, logic [4:0] s, logic [4:0] t);
		in_beat_t b;
		b.opcode = op;
		b.depth = d;
		b.pix_root = r;
		b.pixel_error = e;
		b.first_pixel = f;
		b.remap_slot = s;
		b.remap_target = t;
		return b;
	endfunction

	function automatic logic [15:0] rand_depth();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			3: return 16'($urandom_range(1000, 1100));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void predict_pixel_color(in_beat_t b);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] d;
		logic [15:0] off;
		logic [4:0] root;
		logic [23:0] hue;
		logic [7:0] c;
		logic [7:0] chan [3];
		longint unsigned span;
		longint unsigned prod;
		out_beat_t res;
		res = '0;
		case (b.opcode)
			OP_SCAN: begin
				if (b.first_pixel) begin
					if (!cfg_min_fixed)
						running_min = cfg_max_fixed ? cfg_max_value : b.depth;
					if (!cfg_max_fixed)
						running_max = cfg_min_fixed ? cfg_min_value : running_min;
				end
				if (!b.pixel_error) begin
					if (!cfg_min_fixed && b.depth < running_min) running_min = b.depth;
					if (!cfg_max_fixed && b.depth > running_max) running_max = b.depth;
				end
			end
			OP_LOAD: remap_table[b.remap_slot] = b.remap_target;
			OP_COLOR: begin
				if (b.pixel_error) begin
					res.red = 8'hFF;
					res.green = 8'hFF;
					res.blue = 8'hFF;
					res.was_error = 1'b1;
				end else begin
					lo = cfg_min_fixed ? cfg_min_value : running_min;
					hi = cfg_max_fixed ? cfg_max_value : running_max;
					span = (hi > lo) ? 64'(hi - lo) : 64'd0;
					d = b.depth;
					if (d > hi) d = hi;
					if (d < lo) d = lo;
					off = d - lo;
					root = b.pix_root;
					if (root < cfg_remap_len) root = remap_table[root];
					if (root >= PAL_COUNT) begin
						res.bad_root = 1'b1;
					end else begin
						hue = hue_table[root];
						for (int i = 0; i < 3; i++) begin
							c = hue[23 - 8 * i -: 8];
							if (span == 0) begin
								chan[i] = (d >= hi) ? c : 8'h00;
							end else begin
								prod = 64'(off) * 64'(c);
								chan[i] = 8'(prod / span);
							end
						end
						res.red = chan[0];
						res.green = chan[1];
						res.blue = chan[2];
					end
				end
				pending_colors.push_back(res);
			end
			default: ;
		endcase
	endfunction

	task automatic send_beat(in_beat_t b);
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pixel_color(b);
		if (b.opcode != OP_UNUSED) beats_sent++;
	endtask

	task automatic pace();
		int unsigned n;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				n = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic put_reg(cfg_idx_e idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MIN_FIXED: cfg_min_fixed = val[0];
			CFG_MIN_VALUE: cfg_min_value = val;
			CFG_MAX_FIXED: cfg_max_fixed = val[0];
			CFG_MAX_VALUE: cfg_max_value = val;
			CFG_REMAP_LEN: cfg_remap_len = val[5:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic mf, logic [15:0] mv, logic xf, logic [15:0] xv,
			logic [5:0] rl);
		settle();
		put_reg(CFG_MIN_FIXED, {15'd0, mf});
		put_reg(CFG_MIN_VALUE, mv);
		put_reg(CFG_MAX_FIXED, {15'd0, xf});
		put_reg(CFG_MAX_VALUE, xv);
		put_reg(CFG_REMAP_LEN, {10'd0, rl});
		cfg_we <= 1'b0;
	endtask

	// scan pass over k pixels, then color pass with occasional table loads
	task automatic send_frame(int unsigned k);
		logic [15:0] depth_list [16];
		logic [15:0] d;
		for (int i = 0; i < k; i++) begin
			depth_list[i] = rand_depth();
			pace();
			send_beat(beat(OP_SCAN, depth_list[i], 5'($urandom), $urandom_range(0, 7) == 0,
				i == 0, 5'($urandom), 5'($urandom)));
		end
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				pace();
				send_beat(beat(OP_LOAD, 16'($urandom), 5'($urandom), 1'($urandom),
					1'($urandom), 5'($urandom), 5'($urandom)));
			end
			d = ($urandom_range(0, 3) == 0) ? rand_depth() : depth_list[i];
			pace();
			send_beat(beat(OP_COLOR, d, 5'($urandom), $urandom_range(0, 7) == 0, 1'($urandom),
				5'($urandom), 5'($urandom)));
		end
	endtask

	task automatic test_scan_and_color();
		send_beat(beat(OP_SCAN, 16'd100, 5'd0, 1'b0, 1'b1, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd50, 5'd0, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_SCAN, 16'd0, 5'd0, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_SCAN, 16'hFFFF, 5'd31, 1'b0, 1'b0, 5'd31, 5'd31));
		send_beat(beat(OP_SCAN, 16'd300, 5'd0, 1'b1, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'hFFFF, 5'd20, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd0, 5'd5, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd32768, 5'd8, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd1234, 5'd31, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'hFFFF, 5'd31, 1'b1, 1'b1, 5'd31, 5'd31));
		send_beat(beat(OP_LOAD, 16'd0, 5'd0, 1'b0, 1'b0, 5'd0, 5'd31));
		send_beat(beat(OP_LOAD, 16'd0, 5'd0, 1'b0, 1'b0, 5'd1, 5'd20));
		send_beat(beat(OP_LOAD, 16'd0, 5'd0, 1'b0, 1'b0, 5'd2, 5'd0));
		send_beat(beat(OP_LOAD, 16'd0, 5'd0, 1'b0, 1'b0, 5'd3, 5'd12));
		send_beat(beat(OP_UNUSED, 16'hFFFF, 5'd31, 1'b1, 1'b1, 5'd31, 5'd31));
		// error pixel still seeds the bounds
		send_beat(beat(OP_SCAN, 16'd7, 5'd0, 1'b1, 1'b1, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd7, 5'd4, 1'b0, 1'b0, 5'd0, 5'd0));
	endtask

	task automatic test_fixed_bounds();
		// inverted bounds with remapping
		apply_settings(1'b1, 16'd1000, 1'b1, 16'd10, 6'd4);
		send_beat(beat(OP_COLOR, 16'd500, 5'd0, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'hFFFF, 5'd3, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd0, 5'd1, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_SCAN, 16'd42, 5'd0, 1'b0, 1'b1, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd5, 5'd31, 1'b0, 1'b0, 5'd0, 5'd0));
	endtask

	task automatic test_first_pixel_seeding();
		apply_settings(1'b0, 16'd0, 1'b1, 16'd5000, 6'd0);
		send_beat(beat(OP_SCAN, 16'd9, 5'd0, 1'b0, 1'b1, 5'd0, 5'd0));
		send_beat(beat(OP_SCAN, 16'd100, 5'd0, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd2000, 5'd1, 1'b0, 1'b0, 5'd0, 5'd0));
		apply_settings(1'b1, 16'hFFFF, 1'b0, 16'd0, 6'd2);
		send_beat(beat(OP_SCAN, 16'd3, 5'd0, 1'b0, 1'b1, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd0, 5'd0, 1'b0, 1'b0, 5'd0, 5'd0));
		send_beat(beat(OP_COLOR, 16'd0, 5'd2, 1'b0, 1'b0, 5'd0, 5'd0));
	endtask

	task automatic test_backpressure();
		apply_settings(1'b0, 16'd0, 1'b0, 16'd0, 6'd4);
		gaps_on = 1'b0;
		hold_off_len = 400;
		send_frame(12);
	endtask

	task automatic test_random_frames();
		int unsigned goal;
		for (int s = 0; s < 32; s++) begin
			pace();
			send_beat(beat(OP_LOAD, 16'($urandom), 5'($urandom), 1'($urandom), 1'($urandom),
				5'(s), 5'($urandom)));
		end
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: apply_settings(1'b0, 16'd0, 1'b0, 16'd0, 6'd32);
				1: apply_settings(1'b1, 16'd0, 1'b1, 16'hFFFF, 6'd0);
				2: apply_settings(1'b1, 16'hFFFF, 1'b1, 16'd0, 6'd32);
				3: apply_settings(1'b0, 16'hFFFF, 1'b1, 16'd1050, 6'd21);
				default: apply_settings(1'($urandom), rand_depth(), 1'($urandom), rand_depth(),
					6'($urandom_range(0, 32)));
			endcase
			gaps_on = (p % 3 != 2);
			goal = beats_sent + 120;
			while (beats_sent < goal) begin
				case ($urandom_range(0, 9))
					7: begin
						pace();
						send_beat(beat(OP_LOAD, 16'($urandom), 5'($urandom), 1'($urandom),
							1'($urandom), 5'($urandom), 5'($urandom)));
					end
					8, 9: begin
						pace();
						send_beat(beat(2'($urandom_range(0, 3)), rand_depth(), 5'($urandom),
							1'($urandom), 1'($urandom), 5'($urandom), 5'($urandom)));
					end
					default: send_frame($urandom_range(1, 16));
				endcase
			end
		end
	endtask

	// receiver hold-off and stall patterns
	initial begin : receiver
		int unsigned cyc;
		int unsigned rcv_mode;
		logic [7:0] stall_pattern;
		cyc = 0;
		rcv_mode = 0;
		stall_pattern = 8'hFF;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				out_ready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
			end
			cyc++;
			if (cyc % 200 == 0) begin
				rcv_mode = $urandom_range(0, 3);
				stall_pattern = 8'($urandom) | 8'h01;
			end
			case (rcv_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= stall_pattern[cyc[2:0]];
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin : color_check
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_colors.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected color beat: r=%h g=%h b=%h err=%b bad=%b",
						out_data.red, out_data.green, out_data.blue, out_data.was_error,
						out_data.bad_root);
			end else begin
				want = pending_colors[0];
				pending_colors.delete(0);
				if (out_data.red !== want.red || out_data.green !== want.green ||
						out_data.blue !== want.blue || out_data.was_error !== want.was_error ||
						out_data.bad_root !== want.bad_root) begin
					fail_count++;
					if (fail_count <= 10)
						$display("color mismatch: exp %h %h %h %b %b, got %h %h %h %b %b",
							want.red, want.green, want.blue, want.was_error, want.bad_root,
							out_data.red, out_data.green, out_data.blue, out_data.was_error,
							out_data.bad_root);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("fractal_depth_colorizer test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_scan_and_color();
		test_fixed_bounds();
		test_first_pixel_seeding();
		test_backpressure();
		test_random_frames();
		settle();
		if (fail_count == 0 && pending_colors.size() == 0) begin
			$display("fractal_depth_colorizer test passed");
		end else begin
			$display("fractal_depth_colorizer test failed");
		end
		$finish;
	end

endmodule
